>>> hdl/xml_text_escaper_top_assert.svh
// Assertion macros for the XML text escaper.
// Used by xml_text_escaper_top only; needs clock and reset in scope.
`ifndef XML_TEXT_ESCAPER_TOP_ASSERT_SVH
`define XML_TEXT_ESCAPER_TOP_ASSERT_SVH

// cond must never hold outside reset
`define XTE_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// a in one cycle implies b in the same cycle
`define XTE_IMPLIES(label, a, b, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error(msg);

// a in one cycle implies b in the next cycle
`define XTE_NEXT(label, a, b, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error(msg);

`endif

>>> hdl/xte_pkg.sv
// Shared types, constants and functions of the XML text escaper.
// Used by xte_front, xte_token_queue, xte_back and the top level.
package xte_pkg;

   localparam int WIN_DEPTH = 5;
   localparam int TQ_DEPTH  = 4;
   localparam int TQ_AW     = 2;

   localparam logic [2:0] KIND_PASS = 3'd0;
   localparam logic [2:0] KIND_AMP  = 3'd1;
   localparam logic [2:0] KIND_QUOT = 3'd2;
   localparam logic [2:0] KIND_GT   = 3'd3;
   localparam logic [2:0] KIND_LT   = 3'd4;
   localparam logic [2:0] KIND_APOS = 3'd5;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_QUOT = 8'h22;
   localparam logic [7:0] CH_APOS = 8'h27;
   localparam logic [7:0] CH_LT   = 8'h3c;
   localparam logic [7:0] CH_GT   = 8'h3e;
   localparam logic [7:0] CH_A    = 8'h61;
   localparam logic [7:0] CH_G    = 8'h67;
   localparam logic [7:0] CH_L    = 8'h6c;
   localparam logic [7:0] CH_M    = 8'h6d;
   localparam logic [7:0] CH_O    = 8'h6f;
   localparam logic [7:0] CH_P    = 8'h70;
   localparam logic [7:0] CH_Q    = 8'h71;
   localparam logic [7:0] CH_S    = 8'h73;
   localparam logic [7:0] CH_T    = 8'h74;
   localparam logic [7:0] CH_U    = 8'h75;

   typedef logic [WIN_DEPTH-1:0][7:0] window_type;

   typedef struct packed {
      logic [7:0] data;
      logic [2:0] kind;
      logic       last;
   } token_type;

   // cw[0] is the character to classify, cc the number of valid bytes
   function automatic logic [2:0] xte_classify(window_type cw, logic [2:0] cc);
      logic keep;
      logic [2:0] kind;
      keep = ((cc >= 3'd4) && cw[1] == CH_A && cw[2] == CH_M && cw[3] == CH_P) ||
             ((cc >= 3'd5) && cw[1] == CH_Q && cw[2] == CH_U && cw[3] == CH_O &&
                              cw[4] == CH_T) ||
             ((cc >= 3'd3) && cw[1] == CH_G && cw[2] == CH_T) ||
             ((cc >= 3'd3) && cw[1] == CH_L && cw[2] == CH_T) ||
             ((cc >= 3'd5) && cw[1] == CH_A && cw[2] == CH_P && cw[3] == CH_O &&
                              cw[4] == CH_S);
      priority if (cw[0] == CH_QUOT) kind = KIND_QUOT;
      else if (cw[0] == CH_LT)       kind = KIND_LT;
      else if (cw[0] == CH_GT)       kind = KIND_GT;
      else if (cw[0] == CH_APOS)     kind = KIND_APOS;
      else if (cw[0] == CH_AMP)      kind = keep ? KIND_PASS : KIND_AMP;
      else                           kind = KIND_PASS;
      return kind;
   endfunction

   // index of the final output word of a token
   function automatic logic [2:0] xte_last_idx(logic [2:0] kind);
      logic [2:0] idx;
      unique case (kind)
         KIND_AMP:  idx = 3'd3;
         KIND_QUOT: idx = 3'd4;
         KIND_GT:   idx = 3'd2;
         KIND_LT:   idx = 3'd2;
         KIND_APOS: idx = 3'd4;
         default:   idx = 3'd0;
      endcase
      return idx;
   endfunction

   function automatic logic [7:0] xte_char(logic [2:0] kind, logic [2:0] idx,
                                           logic [7:0] data);
      logic [7:0] ch;
      ch = CH_AMP;
      unique case (kind)
         KIND_AMP: begin
            unique case (idx)
               3'd1:    ch = CH_A;
               3'd2:    ch = CH_M;
               3'd3:    ch = CH_P;
               default: ch = CH_AMP;
            endcase
         end
         KIND_QUOT: begin
            unique case (idx)
               3'd1:    ch = CH_Q;
               3'd2:    ch = CH_U;
               3'd3:    ch = CH_O;
               3'd4:    ch = CH_T;
               default: ch = CH_AMP;
            endcase
         end
         KIND_GT: begin
            unique case (idx)
               3'd1:    ch = CH_G;
               3'd2:    ch = CH_T;
               default: ch = CH_AMP;
            endcase
         end
         KIND_LT: begin
            unique case (idx)
               3'd1:    ch = CH_L;
               3'd2:    ch = CH_T;
               default: ch = CH_AMP;
            endcase
         end
         KIND_APOS: begin
            unique case (idx)
               3'd1:    ch = CH_A;
               3'd2:    ch = CH_P;
               3'd3:    ch = CH_O;
               3'd4:    ch = CH_S;
               default: ch = CH_AMP;
            endcase
         end
         default: ch = data;
      endcase
      return ch;
   endfunction

endpackage

>>> hdl/xte_front.sv
// Front end: five-byte lookahead window, classification and end-of-text flush.
// Depends on xte_pkg.
module xte_front import xte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  logic       tq_full,
   output logic       tok_valid,
   output token_type  tok,
   output logic       flushing
);

   window_type win_ff, win_in, cw;
   logic [2:0] cnt_ff, cnt_in, cc;
   logic       flush_ff, flush_in;
   logic       accept;

   assign full     = flush_ff | tq_full;
   assign accept   = push & ~full;
   assign flushing = flush_ff;

   always_comb begin
      cw = win_ff;
      cc = cnt_ff;
      if (!flush_ff) begin
         cw[cnt_ff] = req_in_byte;
         cc = cnt_ff + 3'd1;
      end
      tok.data = cw[0];
      tok.kind = xte_classify(cw, cc);
      tok.last = flush_ff && (cnt_ff == 3'd1);
      if (flush_ff) begin
         tok_valid = ~tq_full;
      end else begin
         tok_valid = accept && !req_in_last && (cnt_ff == 3'd4);
      end
   end

   always_comb begin
      win_in   = win_ff;
      cnt_in   = cnt_ff;
      flush_in = flush_ff;
      if (flush_ff) begin
         if (!tq_full) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[WIN_DEPTH-1] = 8'd0;
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd1) begin
               flush_in = 1'b0;
            end
         end
      end else if (accept) begin
         if (!req_in_last && cnt_ff == 3'd4) begin
            for (int i = 0; i < WIN_DEPTH - 2; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[WIN_DEPTH-2] = req_in_byte;
         end else begin
            win_in[cnt_ff] = req_in_byte;
            cnt_in = cnt_ff + 3'd1;
            flush_in = req_in_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         cnt_ff   <= 3'd0;
         flush_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         cnt_ff   <= cnt_in;
         flush_ff <= flush_in;
      end
   end

endmodule

>>> hdl/xte_token_queue.sv
// Short queue of classified characters between front and back.
// Depends on xte_pkg.
module xte_token_queue import xte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  token_type wr_tok,
   output logic      tq_full,
   input  logic      rd_en,
   output logic      tq_empty,
   output token_type rd_tok
);

   token_type        mem_ff [TQ_DEPTH];
   logic [TQ_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [TQ_AW:0]   cnt_ff, cnt_in;

   assign tq_full  = (cnt_ff == (TQ_AW+1)'(TQ_DEPTH));
   assign tq_empty = (cnt_ff == '0);
   assign rd_tok   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + TQ_AW'(wr_en);
      rd_ptr_in = rd_ptr_ff + TQ_AW'(rd_en);
      cnt_in    = cnt_ff + (TQ_AW+1)'(wr_en) - (TQ_AW+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> hdl/xte_back.sv
// Back end: expands each token into its output words, two-word output queue.
// Depends on xte_pkg.
module xte_back import xte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       tq_empty,
   input  token_type  tok,
   output logic       tq_pop,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic [2:0] idx_ff, idx_in;
   logic [7:0] ob_ff [2];
   logic       ol_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] oc_ff, oc_in;
   logic       emit, done, take;

   assign take  = pop & ~empty;
   assign empty = (oc_ff == 2'd0);
   assign emit  = ~tq_empty && (oc_ff != 2'd2);
   assign done  = (idx_ff == xte_last_idx(tok.kind));
   assign tq_pop = emit & done;

   assign rsp_out_byte = ob_ff[rp_ff];
   assign rsp_out_last = ol_ff[rp_ff];

   always_comb begin
      idx_in = idx_ff;
      if (emit) begin
         idx_in = done ? 3'd0 : idx_ff + 3'd1;
      end
      wp_in = wp_ff ^ emit;
      rp_in = rp_ff ^ take;
      oc_in = oc_ff + 2'(emit) - 2'(take);
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ob_ff[wp_ff] <= xte_char(tok.kind, idx_ff, tok.data);
         ol_ff[wp_ff] <= tok.last & done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         oc_ff  <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         oc_ff  <= oc_in;
      end
   end

endmodule

>>> hdl/xml_text_escaper_top.sv
// XML text escaper, top level.
// Input side is a queue: write a word with push while full is low; req_in_last
// marks the final character of a text. Output side is a queue: while empty is
// low the oldest escaped word sits on rsp_out_byte/rsp_out_last; pop takes it.
// Characters " < > ' become &quot &lt &gt &apos; an ampersand that does not
// start amp, quot, gt, lt or apos becomes &amp. No semicolons are added.
// A character leaves the front once the four characters after it have
// arrived, or when its text ends, then passes through the token queue and
// the two-word output queue to the result ports. The back end produces one
// output word per cycle while a token waits and the output queue has room;
// a plain character yields one word, an entity three to five. Input is taken
// every cycle while the four-entry token queue has room and no flush runs.
// After a word with req_in_last the front drains its window, one character
// per cycle (up to five) while the token queue has room, holding full high.
// When the receiver stalls, both queues fill, full rises; nothing is dropped.
// Reset (synchronous, active high) empties the window and both queues.
// Depends on xte_pkg, xte_front, xte_token_queue, xte_back and
// xml_text_escaper_top_assert.svh.
`include "xml_text_escaper_top_assert.svh"

module xml_text_escaper_top import xte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   token_type f_tok, q_tok;
   logic      f_valid, tq_full, tq_empty, tq_pop, flushing;

   xte_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .tq_full     (tq_full),
      .tok_valid   (f_valid),
      .tok         (f_tok),
      .flushing    (flushing)
   );

   xte_token_queue u_tq (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (f_valid),
      .wr_tok   (f_tok),
      .tq_full  (tq_full),
      .rd_en    (tq_pop),
      .tq_empty (tq_empty),
      .rd_tok   (q_tok)
   );

   xte_back u_back (
      .clock        (clock),
      .reset        (reset),
      .tq_empty     (tq_empty),
      .tok          (q_tok),
      .tq_pop       (tq_pop),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   `XTE_NEVER(a_no_push_when_full, f_valid && tq_full, "token pushed into full queue")
   `XTE_IMPLIES(a_flush_blocks_input, flushing, full, "input taken during flush")
   `XTE_NEVER(a_no_pop_when_empty, tq_pop && tq_empty, "token popped from empty queue")
   `XTE_NEXT(a_last_ends_flush, f_valid && f_tok.last, !flushing, "flush ran past last word")

endmodule
